// ===== sv/slfd_pkg.sv =====
// Shared types and constants for the sync/length frame deframer.
// Holds the controller state encoding, the command/status bundles and register indexes.
// No dependencies.
`default_nettype none

package slfd_pkg;

  localparam int CNT_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER_BYTES = 2'd2;

  localparam logic [15:0] SYNC_WORD_RST     = 16'h55AA;
  localparam logic [15:0] MAX_PAYLOAD_RST   = 16'd1024;
  localparam logic [2:0]  TRAILER_BYTES_RST = 3'd2;

  typedef enum logic [3:0] {
    ST_HUNT  = 4'b0001,
    ST_HEAD  = 4'b0010,
    ST_BURST = 4'b0100,
    ST_BODY  = 4'b1000
  } state_t;

  typedef struct packed {
    logic hunt_step;
    logic head_step;
    logic body_step;
    logic burst_emit;
    logic end_frame;
  } cmd_t;

  typedef struct packed {
    logic sync_hit;
    logic hdr_done;
    logic len_ok;
    logic body_end;
    logic burst_done;
    logic short_frame;
    logic replay_active;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/slfd_in_if.sv =====
// Byte request channel into the deframer: valid/ready handshake plus one byte.
// Stand-alone, no package dependency.
`default_nettype none

interface slfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

// ===== sv/slfd_out_if.sv =====
// Result channel out of the deframer: valid/ready handshake, frame byte and markers.
// Stand-alone, no package dependency.
`default_nettype none

interface slfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic       burst_last;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output burst_last, input ready);
  modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                  input burst_last, output ready);
endinterface

`default_nettype wire

// ===== sv/slfd_ctrl.sv =====
// Deframer controller: hunt / header / burst / body state machine.
// Uses slfd_pkg for the state encoding and the command/status bundles.
`default_nettype none

module slfd_ctrl
  import slfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t st_r, st_nxt;
  logic   take_in;
  logic   step;

  always_comb begin
    // input is blocked while held header bytes are replayed
    take_in = !sts.replay_active &&
              ((st_r == ST_HUNT) || (st_r == ST_HEAD) || ((st_r == ST_BODY) && sts.out_free));
    in_ready = take_in;
    step     = sts.replay_active || (take_in && in_valid);

    cmd            = '0;
    cmd.hunt_step  = step && (st_r == ST_HUNT);
    cmd.head_step  = step && (st_r == ST_HEAD);
    cmd.body_step  = step && (st_r == ST_BODY);
    cmd.burst_emit = (st_r == ST_BURST) && sts.out_free;

    st_nxt = st_r;
    case (st_r)
      ST_HUNT: begin
        if (cmd.hunt_step && sts.sync_hit) st_nxt = ST_HEAD;
      end
      ST_HEAD: begin
        if (cmd.head_step && sts.hdr_done) begin
          st_nxt = sts.len_ok ? ST_BURST : ST_HUNT;
        end
      end
      ST_BURST: begin
        if (cmd.burst_emit && sts.burst_done) begin
          if (sts.short_frame) begin
            st_nxt        = ST_HUNT;
            cmd.end_frame = 1'b1;
          end else begin
            st_nxt = ST_BODY;
          end
        end
      end
      ST_BODY: begin
        if (cmd.body_step && sts.body_end) begin
          st_nxt        = ST_HUNT;
          cmd.end_frame = 1'b1;
        end
      end
      default: st_nxt = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_HUNT;
    end else begin
      st_r <= st_nxt;
    end
  end

  a_replay_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sts.replay_active |-> !in_ready)
    else $error("input taken during header replay");

  a_end_frame_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.end_frame |=> (st_r == ST_HUNT))
    else $error("frame end did not return to hunting");

  a_burst_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.head_step && sts.hdr_done && sts.len_ok) |=> (st_r == ST_BURST))
    else $error("accepted header did not start the release burst");

endmodule

`default_nettype wire

// ===== sv/slfd_dp.sv =====
// Deframer datapath: config registers, sync compare, held header bytes, byte counters,
// replay and burst indexes, and the output register. Uses slfd_pkg.
`default_nettype none

module slfd_dp
  import slfd_pkg::*;
#(
  parameter int HEADER_BYTES  = 8,
  parameter int LENGTH_OFFSET = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [7:0]            in_byte,
  input  wire cmd_t                  cmd,
  output sts_t                       sts,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_byte,
  output logic                       frame_first,
  output logic                       frame_last,
  output logic                       burst_last
);

  localparam int HDR_EFF = (HEADER_BYTES > LENGTH_OFFSET + 2) ? HEADER_BYTES
                                                               : LENGTH_OFFSET + 2;
  localparam int BURST_N = LENGTH_OFFSET + 2;
  localparam int LIW     = $clog2(LENGTH_OFFSET);
  localparam int BIW     = $clog2(BURST_N);

  localparam logic [CNT_W-1:0] BURST_N_C   = CNT_W'(BURST_N);
  localparam logic [CNT_W-1:0] HDR_EFF_C   = CNT_W'(HDR_EFF);
  localparam logic [LIW-1:0]   REPLAY_LAST = LIW'(LENGTH_OFFSET - 1);
  localparam logic [BIW-1:0]   BURST_LAST  = BIW'(BURST_N - 1);

  logic [15:0]      sync_word_r;
  logic [15:0]      max_payload_r;
  logic [2:0]       trailer_r;
  logic [7:0]       prev_byte_r;
  logic             prev_valid_r;
  logic [7:0]       held_r [LENGTH_OFFSET];
  logic [CNT_W-1:0] byte_count_r;
  logic [CNT_W-1:0] frame_total_r;
  logic [BIW-1:0]   burst_idx_r;
  logic [LIW-1:0]   replay_idx_r;
  logic             replay_active_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             first_r;
  logic             last_r;
  logic             blast_r;

  logic [BIW-1:0]   burst_sub;
  logic [LIW-1:0]   rd_idx;
  logic [7:0]       rd_byte;
  logic [7:0]       cur;
  logic [CNT_W-1:0] bc_inc;
  logic [CNT_W-1:0] wr_full;
  logic [LIW-1:0]   wr_idx;
  logic [15:0]      len;
  logic [CNT_W-1:0] ft_new;
  logic             reject;
  logic             load;
  logic [7:0]       ld_byte;
  logic             ld_first;
  logic             ld_last;
  logic             ld_blast;

  always_comb begin
    burst_sub = burst_idx_r - BIW'(2);
    rd_idx    = replay_active_r ? replay_idx_r : burst_sub[LIW-1:0];
    rd_byte   = held_r[rd_idx];
    cur       = replay_active_r ? rd_byte : in_byte;
    bc_inc    = byte_count_r + CNT_W'(1);
    wr_full   = byte_count_r - CNT_W'(2);
    wr_idx    = wr_full[LIW-1:0];
    // low length byte is the one arriving now
    len       = {held_r[LENGTH_OFFSET-2], cur};
    ft_new    = HDR_EFF_C + CNT_W'(len) + CNT_W'(trailer_r);

    sts.sync_hit      = prev_valid_r && (prev_byte_r == sync_word_r[15:8]) &&
                        (cur == sync_word_r[7:0]);
    sts.hdr_done      = bc_inc >= BURST_N_C;
    sts.len_ok        = len <= max_payload_r;
    sts.body_end      = bc_inc >= frame_total_r;
    sts.burst_done    = burst_idx_r == BURST_LAST;
    sts.short_frame   = frame_total_r <= BURST_N_C;
    sts.replay_active = replay_active_r;
    sts.out_free      = !out_valid_r || out_ready;

    reject = cmd.head_step && sts.hdr_done && !sts.len_ok;
    load   = cmd.body_step || cmd.burst_emit;

    if (cmd.burst_emit) begin
      case (burst_idx_r)
        BIW'(0):  ld_byte = sync_word_r[15:8];
        BIW'(1):  ld_byte = sync_word_r[7:0];
        default:  ld_byte = rd_byte;
      endcase
      ld_first = burst_idx_r == BIW'(0);
      ld_last  = frame_total_r == (CNT_W'(burst_idx_r) + CNT_W'(1));
      ld_blast = sts.burst_done;
    end else begin
      ld_byte  = cur;
      ld_first = 1'b0;
      ld_last  = bc_inc == frame_total_r;
      ld_blast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r     <= SYNC_WORD_RST;
      max_payload_r   <= MAX_PAYLOAD_RST;
      trailer_r       <= TRAILER_BYTES_RST;
      prev_valid_r    <= 1'b0;
      byte_count_r    <= '0;
      frame_total_r   <= '0;
      burst_idx_r     <= '0;
      replay_idx_r    <= '0;
      replay_active_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SYNC_WORD:     sync_word_r   <= cfg_data;
          CFG_MAX_PAYLOAD:   max_payload_r <= cfg_data;
          CFG_TRAILER_BYTES: trailer_r     <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (replay_active_r) begin
        replay_idx_r <= replay_idx_r + LIW'(1);
        if (replay_idx_r == REPLAY_LAST) replay_active_r <= 1'b0;
      end

      if (cmd.hunt_step) begin
        if (sts.sync_hit) begin
          byte_count_r <= CNT_W'(2);
          prev_valid_r <= 1'b0;
        end else begin
          prev_valid_r <= 1'b1;
        end
      end

      if (cmd.head_step) begin
        if (reject) begin
          // drop the header and rerun the held bytes through the hunter
          byte_count_r    <= '0;
          prev_valid_r    <= 1'b0;
          replay_active_r <= 1'b1;
          replay_idx_r    <= '0;
        end else begin
          byte_count_r <= bc_inc;
          if (sts.hdr_done) frame_total_r <= ft_new;
        end
      end

      if (cmd.body_step && !cmd.end_frame) byte_count_r <= bc_inc;

      if (cmd.burst_emit) begin
        burst_idx_r <= sts.burst_done ? '0 : burst_idx_r + BIW'(1);
      end

      if (cmd.end_frame) begin
        byte_count_r <= '0;
        prev_valid_r <= 1'b0;
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hunt_step && !sts.sync_hit) prev_byte_r <= cur;
    if (cmd.head_step) held_r[wr_idx] <= cur;
    if (load) begin
      out_byte_r <= ld_byte;
      first_r    <= ld_first;
      last_r     <= ld_last;
      blast_r    <= ld_blast;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign frame_first = first_r;
  assign frame_last  = last_r;
  assign burst_last  = blast_r;

  a_reject_starts_replay: assert property (@(posedge clk) disable iff (!rst_n)
    reject |=> replay_active_r)
    else $error("rejected header did not start replay");

  a_body_within_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.body_step |-> (byte_count_r < frame_total_r))
    else $error("body byte beyond frame length");

  a_load_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> sts.out_free)
    else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire

// ===== sv/sync_length_frame_deframer_core.sv =====
// Sync-word / length-prefixed frame deframer, top level.
// in_chan takes one received byte per request (valid/ready). While hunting, a two-byte
// sync word (cfg register 0, high byte first) opens a header; bytes up to and including
// the big-endian length field at LENGTH_OFFSET are held back. A length above
// max_payload (cfg register 1) rejects the header: the held bytes are replayed through
// the hunter, one per cycle, with in_chan.ready low. A valid length releases sync word
// and held bytes on out_chan, LENGTH_OFFSET+2 requests, one per cycle while out_chan is
// not stalled; then the rest of the header, payload and trailer_bytes (cfg register 2)
// pass through with frame_first / frame_last marked and burst_last on the last result
// of each input. A body byte appears on out_chan the cycle after it is accepted; after
// the header byte that completes the length, input waits while the burst is emitted
// through the single output register.
// The output register decouples the sides: a new byte is taken while a result waits,
// as long as that byte gives no result or the waiting one leaves in the same cycle.
// When out_chan stalls the output register holds and body input is back-pressured.
// Reset (rst_n, synchronous) restores the register defaults and returns to hunting.
// cfg_we writes cfg_data to register cfg_index; unknown indexes are ignored.
`default_nettype none

module sync_length_frame_deframer_core
  import slfd_pkg::*;
#(
  parameter int HEADER_BYTES  = 8,
  parameter int LENGTH_OFFSET = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  slfd_in_if.sink                    in_chan,
  slfd_out_if.source                 out_chan
);

  cmd_t cmd;
  sts_t sts;

  slfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  slfd_dp #(
    .HEADER_BYTES  (HEADER_BYTES),
    .LENGTH_OFFSET (LENGTH_OFFSET)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_byte     (in_chan.in_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_byte    (out_chan.out_byte),
    .frame_first (out_chan.frame_first),
    .frame_last  (out_chan.frame_last),
    .burst_last  (out_chan.burst_last)
  );

endmodule

`default_nettype wire
